/* rtl/core/tcft_pkg.sv */
// ----------------------------------------------------------------------------
// tcft_pkg
// shared types, constants and text tables of the tick count to text unit
// ----------------------------------------------------------------------------
package tcft_pkg;

    localparam int DivWidth = 32;

    // register indexes on the configuration port
    localparam logic RegTicksPerUs = 1'b0;
    localparam logic RegCyclesK    = 1'b1;

    localparam logic [4:0]  HeadLen  = 5'd11;
    localparam logic [4:0]  TailLast = 5'd16;   // head length plus tail length minus one
    localparam logic [15:0] FreqMax  = 16'hFFFF;
    localparam logic [15:0] RecipTen = 16'hCCCD; // 2^19 / 10, rounded up
    localparam logic [7:0]  AsciiZero = 8'h30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_PERIOD,
        ST_DIV_FREQ,
        ST_DIGITS,
        ST_EMIT
    } t_state;

    function automatic logic [7:0] head_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h57; // W
            4'd1:    ch = 8'h44; // D
            4'd2:    ch = 8'h54; // T
            4'd3:    ch = 8'h20;
            4'd4:    ch = 8'h46; // F
            4'd5:    ch = 8'h52; // R
            4'd6:    ch = 8'h45; // E
            4'd7:    ch = 8'h51; // Q
            4'd8:    ch = 8'h20;
            4'd9:    ch = 8'h3D; // =
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] tail_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h20;
            3'd1:    ch = 8'h6B; // k
            3'd2:    ch = 8'h48; // H
            3'd3:    ch = 8'h7A; // z
            3'd4:    ch = 8'h0D; // CR
            default: ch = 8'h0A; // LF
        endcase
        return ch;
    endfunction

endpackage

/* rtl/core/tick_count_to_freq_text_unit.sv */
// ----------------------------------------------------------------------------
// tick_count_to_freq_text_unit
// turns one timer measurement into the text line "WDT FREQ = <n> kHz" CR LF
// ----------------------------------------------------------------------------
// One input word (overflow count, timer count) gives ticks = overflows*65536
// + timer. A shared 32-step restoring divider first forms the period in
// microseconds (ticks / ticks_per_microsecond, a zero divisor counts as 1),
// then the frequency in kHz (cycles_times_thousand / period), saturated at
// 65535; a zero period also gives 65535. Decimal digits come out one per
// cycle through a multiply by the reciprocal of ten. The text is then sent
// one byte per output word, 18 to 22 bytes, last_byte marking the final LF.
// An all-zero measurement is taken and produces nothing. The input stays
// stalled from an accepted word until the unit is back in idle: the period
// division, the frequency division (skipped for a zero period), the digit
// steps (up to 5 digits) and the text bytes, which wait while the output side
// stalls. The last byte sits in the output register while the next word is
// already accepted.
// Registers: 0x0 ticks_per_microsecond (7 bits, reset 16),
//            0x4 cycles_times_thousand (32 bits, reset 4096000).
// ----------------------------------------------------------------------------
module tick_count_to_freq_text_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // measurement word in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_overflow_count,
    input  logic [15:0] i_timer_count,
    // text word out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_text_byte,
    output logic        o_last_byte
);
    import tcft_pkg::*;

    // configuration registers
    logic [6:0]  r_tpm;
    logic [31:0] r_ctk;

    logic cfg_wr;
    logic cfg_idx;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm <= 7'd16;
            r_ctk <= 32'd4096000;
        end else if (cfg_wr) begin
            case (cfg_idx)
                RegTicksPerUs: r_tpm <= pwdata[6:0];
                RegCyclesK:    r_ctk <= pwdata;
                default:       r_ctk <= r_ctk;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            RegTicksPerUs: prdata = {25'd0, r_tpm};
            RegCyclesK:    prdata = r_ctk;
            default:       prdata = '0;
        endcase
    end

    // sequencer state
    t_state      r_state, n_state;
    logic [15:0] r_freq;
    logic [3:0]  r_digits [5];
    logic [2:0]  r_nd;
    logic [4:0]  r_k;
    logic        r_o_valid;
    logic [7:0]  r_o_byte;
    logic        r_o_last;

    logic accept;
    logic zero_meas;
    assign o_stall   = (r_state != ST_IDLE);
    assign accept    = i_valid && !o_stall;
    assign zero_meas = (i_overflow_count == 8'd0) && (i_timer_count == 16'd0);

    // shared divider hookup
    logic        div_start;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quot;
    logic [6:0]  tpm_eff;

    assign tpm_eff = (r_tpm == 7'd0) ? 7'd1 : r_tpm;

    tcft_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // period and frequency from the divider
    logic period_zero;
    logic [15:0] freq_sat;
    assign period_zero = (div_quot[23:0] == 24'd0);
    assign freq_sat    = (div_quot[31:16] != 16'd0) ? FreqMax : div_quot[15:0];

    // digit step: divide by ten via reciprocal multiply
    logic [31:0] prod;
    logic [12:0] q10;
    logic [15:0] rem10;
    assign prod  = r_freq * RecipTen;
    assign q10   = prod[31:19];
    assign rem10 = r_freq - {q10, 3'b000} - {2'b00, q10, 1'b0};

    // text byte at position r_k
    logic [4:0] digit_end;
    logic [4:0] dig_pos;
    logic [4:0] tail_pos;
    logic [7:0] cur_char;
    logic       cur_last;
    logic       out_load;

    always_comb begin
        digit_end = HeadLen + {2'b00, r_nd};
        dig_pos   = {2'b00, r_nd} + 5'd10 - r_k;
        tail_pos  = r_k - digit_end;
        if (r_k < HeadLen) begin
            cur_char = head_char(r_k[3:0]);
        end else if (r_k < digit_end) begin
            cur_char = AsciiZero + {4'd0, r_digits[dig_pos[2:0]]};
        end else begin
            cur_char = tail_char(tail_pos[2:0]);
        end
        cur_last = (r_k == (TailLast + {2'b00, r_nd}));
        out_load = (r_state == ST_EMIT) && (!r_o_valid || !i_stall);
    end

    // next state and divider requests
    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = {8'd0, i_overflow_count, i_timer_count};
        div_divisor  = {25'd0, tpm_eff};
        case (r_state)
            ST_IDLE: begin
                if (accept && !zero_meas) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV_PERIOD;
                end
            end
            ST_DIV_PERIOD: begin
                div_dividend = r_ctk;
                div_divisor  = {8'd0, div_quot[23:0]};
                if (div_done) begin
                    if (period_zero) begin
                        n_state = ST_DIGITS;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV_FREQ;
                    end
                end
            end
            ST_DIV_FREQ: begin
                if (div_done) begin
                    n_state = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (q10 == 13'd0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && cur_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_DIV_PERIOD: begin
                r_nd <= 3'd0;
                if (div_done && period_zero) begin
                    r_freq <= FreqMax;
                end
            end
            ST_DIV_FREQ: begin
                r_nd <= 3'd0;
                if (div_done) begin
                    r_freq <= freq_sat;
                end
            end
            ST_DIGITS: begin
                r_digits[r_nd] <= rem10[3:0];
                r_nd           <= r_nd + 3'd1;
                r_freq         <= {3'd0, q10};
                r_k            <= 5'd0;
            end
            ST_EMIT: begin
                if (out_load) begin
                    r_k <= r_k + 5'd1;
                end
            end
            default: r_k <= 5'd0;
        endcase
    end

    // output register, holds while the far side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_byte <= cur_char;
            r_o_last <= cur_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_text_byte = r_o_byte;
    assign o_last_byte = r_o_last;

endmodule

/* rtl/core/tcft_divider.sv */
// ----------------------------------------------------------------------------
// tcft_divider
// restoring divider, one quotient bit per cycle, shared by both divisions
// ----------------------------------------------------------------------------
module tcft_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcft_pkg::DivWidth-1:0] i_dividend,
    input  logic [tcft_pkg::DivWidth-1:0] i_divisor,
    output logic                         o_done,
    output logic [tcft_pkg::DivWidth-1:0] o_quotient
);
    import tcft_pkg::*;

    logic                r_busy;
    logic [4:0]          r_cnt;
    logic [DivWidth-1:0] r_rem;
    logic [DivWidth-1:0] r_quot;
    logic [DivWidth-1:0] r_div;

    logic [DivWidth:0]   rem_sh;
    logic                ge;
    logic [DivWidth:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quot[DivWidth-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd31;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? rem_sub[DivWidth-1:0] : rem_sh[DivWidth-1:0];
            r_quot <= {r_quot[DivWidth-2:0], ge};
        end
    end

    // quotient is complete once the last step has been written
    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd0) && !i_start;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

/* bench/tick_count_to_freq_text_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_count_to_freq_text_unit_test
// self-checking bench for the timer measurement to frequency text unit
// ----------------------------------------------------------------------------
// Drives measurement words under several register settings and idling mixes,
// predicts the "WDT FREQ = <n> kHz" CR LF text of each one, and compares every
// output word in order against the predicted bytes.
// ----------------------------------------------------------------------------

import tcft_pkg::*;

typedef struct packed {
    logic [7:0] text;
    logic       last;
} text_word_t;

// predicts the report text and checks the output words against it
class report_text_tracker;
    logic [6:0]  ticks_per_us;
    logic [31:0] cycles_k;
    text_word_t  pending_text[$];
    int          errors;

    function new();
        ticks_per_us = 7'd16;
        cycles_k     = 32'd4096000;
        errors       = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] data);
        if (idx == RegTicksPerUs) begin
            ticks_per_us = data[6:0];
        end else begin
            cycles_k = data;
        end
    endfunction

    function logic [15:0] freq_khz(logic [31:0] ticks);
        logic [31:0] divisor;
        logic [31:0] period;
        logic [31:0] quot;
        divisor = (ticks_per_us == 7'd0) ? 32'd1 : {25'd0, ticks_per_us};
        period  = ticks / divisor;
        if (period == 32'd0) begin
            return FreqMax;
        end
        quot = cycles_k / period;
        return (quot > {16'd0, FreqMax}) ? FreqMax : quot[15:0];
    endfunction

    function void push_char(logic [7:0] ch, logic last);
        text_word_t w;
        w.text = ch;
        w.last = last;
        pending_text.push_back(w);
    endfunction

    function void take_measurement(logic [7:0] ovf, logic [15:0] tmr);
        string       head;
        string       digits;
        string       unit;
        logic [31:0] ticks;
        if (ovf == 8'd0 && tmr == 16'd0) begin
            return;
        end
        ticks  = {8'd0, ovf, tmr};
        head   = "WDT FREQ = ";
        unit   = " kHz";
        digits = $sformatf("%0d", freq_khz(ticks));
        for (int i = 0; i < head.len(); i++) begin
            push_char(head[i], 1'b0);
        end
        for (int i = 0; i < digits.len(); i++) begin
            push_char(digits[i], 1'b0);
        end
        for (int i = 0; i < unit.len(); i++) begin
            push_char(unit[i], 1'b0);
        end
        push_char(8'h0D, 1'b0);   // carriage return
        push_char(8'h0A, 1'b1);   // line feed closes the message
    endfunction

    function void match_byte(logic [7:0] text, logic last);
        text_word_t want;
        if (pending_text.size() == 0) begin
            $error("unexpected text word %h (last %b)", text, last);
            errors++;
            return;
        end
        want = pending_text.pop_front();
        if (text !== want.text) begin
            $error("text_byte: expected %h, actual %h", want.text, text);
            errors++;
        end
        if (last !== want.last) begin
            $error("last_byte: expected %b, actual %b", want.last, last);
            errors++;
        end
    endfunction
endclass

module tick_count_to_freq_text_unit_test;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_overflow_count = 8'd0;
    logic [15:0] i_timer_count = 16'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_text_byte;
    logic        o_last_byte;

    // idling mix of the current phase, in percent per cycle
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    report_text_tracker tracker = new();

    tick_count_to_freq_text_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_overflow_count (i_overflow_count),
        .i_timer_count    (i_timer_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_text_byte      (o_text_byte),
        .o_last_byte      (o_last_byte)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // every word taken on the output side is checked in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.match_byte(o_text_byte, o_last_byte);
        end
    end

    // register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_register(idx, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // present one measurement word and hold it until the unit takes it
    task automatic send_measurement(input logic [7:0] ovf, input logic [15:0] tmr);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_overflow_count = ovf;
        i_timer_count    = tmr;
        do @(posedge i_clk); while (o_stall);
        tracker.take_measurement(ovf, tmr);
    endtask

    // let all predicted text drain, then keep checking for any unexpected text word
    task automatic drain_reports();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (tracker.pending_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        int          pick;
        logic [6:0]  tpu;
        logic [31:0] cyc;
        logic [7:0]  ovf;
        logic [15:0] tmr;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: 16 ticks per us, 4096000
        send_measurement(8'd0, 16'd0);          // all-zero, no text
        send_measurement(8'd0, 16'd1);          // period rounds to zero
        send_measurement(8'd0, 16'd16);         // period 1, frequency saturates
        send_measurement(8'd255, 16'hFFFF);     // largest tick count
        send_measurement(8'd0, 16'hFFFF);
        send_measurement(8'd128, 16'd0);
        send_measurement(8'h55, 16'hAAAA);
        send_measurement(8'hAA, 16'h5555);
        send_measurement(8'd62, 16'd32768);
        drain_reports();

        // smallest numerator: one-digit frequencies of 1 and 0
        write_reg(RegTicksPerUs, 32'd1);
        write_reg(RegCyclesK, 32'd1);
        send_measurement(8'd0, 16'd1);
        send_measurement(8'd0, 16'd2);
        send_measurement(8'd255, 16'hFFFF);
        drain_reports();

        // zero divisor counts as one, largest numerator
        write_reg(RegTicksPerUs, 32'hFFFF_FF80);
        write_reg(RegCyclesK, 32'hFFFF_FFFF);
        send_measurement(8'd0, 16'd1);
        send_measurement(8'd255, 16'hFFFF);
        send_measurement(8'd1, 16'd0);
        drain_reports();

        // largest 7-bit divisor
        write_reg(RegTicksPerUs, 32'd127);
        write_reg(RegCyclesK, 32'd1000000);
        send_measurement(8'd0, 16'd126);
        send_measurement(8'd0, 16'd127);
        send_measurement(8'd255, 16'hFFFF);
        send_measurement(8'd3, 16'd1234);
        drain_reports();

        // random phases: none, sender idle, receiver stall, both lightly
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase

            pick = $urandom_range(9);
            if (pick == 0) begin
                tpu = 7'd0;
            end else if (pick == 1) begin
                tpu = 7'($urandom_range(65, 127));
            end else begin
                tpu = 7'($urandom_range(1, 64));
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
                cyc = $urandom_range(1, 1000);
            end else if (pick == 1) begin
                cyc = 32'hFFFF_FFFF;
            end else if (pick < 5) begin
                cyc = $urandom;
            end else begin
                cyc = $urandom_range(100000, 20000000);
            end
            // upper bits of the divisor write are don't-care
            write_reg(RegTicksPerUs, {25'($urandom), tpu});
            write_reg(RegCyclesK, cyc);

            for (int n = 0; n < 40; n++) begin
                pick = $urandom_range(19);
                tmr  = 16'($urandom);
                if (pick == 0) begin
                    ovf = 8'd0;
                    tmr = 16'd0;
                end else if (pick < 5) begin
                    ovf = 8'd0;      // short periods, high frequencies
                end else if (pick < 8) begin
                    ovf = 8'($urandom_range(0, 3));
                end else begin
                    ovf = 8'($urandom);
                end
                send_measurement(ovf, tmr);
            end
            drain_reports();
        end

        if (tracker.errors == 0 && tracker.pending_text.size() == 0) begin
            $display("tick_count_to_freq_text_unit test passed");
        end else begin
            $display("tick_count_to_freq_text_unit test failed");
        end
        $finish;
    end

    // watchdog on the whole run
    initial begin
        #10000000;
        $display("tick_count_to_freq_text_unit test failed");
        $finish;
    end

endmodule
